// ===== hdl/i2cm_pkg.sv =====
// Package for the single-register I2C master: payload structs, segment codes,
// the transaction programs and timing constants. No dependencies.
`default_nettype none

package i2cm_pkg;

  // Width of the phase hold counter and of the phase_ticks register
  localparam int unsigned TickCw = 16;
  localparam logic [TickCw-1:0] PhaseTicksRst = TickCw'(30);

  // Program position: 0 is idle, 1..11 index the segment programs
  localparam int unsigned PosW = 4;
  localparam int unsigned SubW = 2;

  // Bus segment codes
  typedef enum logic [3:0] {
    SEG_END,
    SEG_START,
    SEG_SEND_DEV,
    SEG_SEND_REG,
    SEG_SEND_DAT,
    SEG_SEND_DEVR,
    SEG_ACK,
    SEG_RECV,
    SEG_NACK,
    SEG_STOP
  } seg_e;

  // Input transaction
  typedef struct packed {
    logic       func;
    logic       is_read;
    logic [7:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } out_item_t;

  // Segment at a program position for a read or a write transaction
  function automatic seg_e seg_at(input logic is_read, input logic [PosW-1:0] pos);
    seg_e seg;
    seg = SEG_END;
    if (is_read) begin
      case (pos)
        4'd1:    seg = SEG_START;
        4'd2:    seg = SEG_SEND_DEV;
        4'd3:    seg = SEG_ACK;
        4'd4:    seg = SEG_SEND_REG;
        4'd5:    seg = SEG_ACK;
        4'd6:    seg = SEG_START;
        4'd7:    seg = SEG_SEND_DEVR;
        4'd8:    seg = SEG_ACK;
        4'd9:    seg = SEG_RECV;
        4'd10:   seg = SEG_NACK;
        4'd11:   seg = SEG_STOP;
        default: seg = SEG_END;
      endcase
    end else begin
      case (pos)
        4'd1:    seg = SEG_START;
        4'd2:    seg = SEG_SEND_DEV;
        4'd3:    seg = SEG_ACK;
        4'd4:    seg = SEG_SEND_REG;
        4'd5:    seg = SEG_ACK;
        4'd6:    seg = SEG_SEND_DAT;
        4'd7:    seg = SEG_ACK;
        4'd8:    seg = SEG_STOP;
        default: seg = SEG_END;
      endcase
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/i2cm_seq.sv =====
// Bus phase sequencer: holds the transaction state and the phase_ticks
// register, and works out the result for one item. Depends on i2cm_pkg.
`default_nettype none

module i2cm_seq import i2cm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TickCw-1:0] cfg_data_i,
  input  wire logic              step_i,
  input  wire in_item_t          item_i,
  output out_item_t              res_o
);

  logic [TickCw-1:0] ticks_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [SubW-1:0]   sub_q, sub_d;
  logic [TickCw-1:0] cnt_q, cnt_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        tx_q, tx_d;
  logic [7:0]        rx_q, rx_d;
  logic [7:0]        rxres_q, rxres_d;
  logic              rd_q, rd_d;
  logic [7:0]        dev_q, dev_d;
  logic [7:0]        reg_q, reg_d;
  logic [7:0]        dat_q, dat_d;
  logic              nack_q, nack_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              done;

  // Next state for one item
  always_comb begin
    logic [TickCw-1:0] limit;
    logic [TickCw:0]   cnt_inc;
    logic              go_enter;
    logic              new_seg;
    logic [PosW-1:0]   tgt_pos;
    logic [SubW-1:0]   tgt_sub;
    seg_e              cur_seg;
    seg_e              tgt_seg;

    pos_d   = pos_q;
    sub_d   = sub_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    rxres_d = rxres_q;
    rd_d    = rd_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    dat_d   = dat_q;
    nack_d  = nack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    done    = 1'b0;

    go_enter = 1'b0;
    new_seg  = 1'b0;
    tgt_pos  = pos_q;
    tgt_sub  = '0;

    // zero hold is treated as one tick
    limit   = (ticks_q == '0) ? TickCw'(1) : ticks_q;
    cnt_inc = {1'b0, cnt_q} + (TickCw+1)'(1);
    cur_seg = seg_at(rd_q, pos_q);

    if (item_i.func) begin
      // command: ignored while a transaction runs
      if (pos_q == '0) begin
        rd_d     = item_i.is_read;
        dev_d    = item_i.device_addr;
        reg_d    = item_i.reg_addr;
        dat_d    = item_i.write_data;
        nack_d   = 1'b0;
        cnt_d    = '0;
        go_enter = 1'b1;
        new_seg  = 1'b1;
        tgt_pos  = PosW'(1);
        tgt_sub  = '0;
      end
    end else if (pos_q != '0) begin
      if (cnt_inc >= {1'b0, limit}) begin
        cnt_d = '0;
        // end of the current phase
        case (cur_seg)
          SEG_SEND_DEV, SEG_SEND_REG, SEG_SEND_DAT, SEG_SEND_DEVR: begin
            go_enter = 1'b1;
            if (sub_q < 2'd2) begin
              tgt_sub = sub_q + 2'd1;
            end else begin
              tx_d  = {tx_q[6:0], 1'b0};
              bit_d = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                new_seg = 1'b1;
                tgt_pos = pos_q + PosW'(1);
              end
            end
          end
          SEG_RECV: begin
            go_enter = 1'b1;
            if (sub_q == '0) begin
              rx_d    = {rx_q[6:0], item_i.sda_in};
              tgt_sub = 2'd1;
            end else begin
              bit_d = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                rxres_d = rx_q;
                new_seg = 1'b1;
                tgt_pos = pos_q + PosW'(1);
              end
            end
          end
          SEG_STOP: begin
            if (sub_q < 2'd2) begin
              go_enter = 1'b1;
              tgt_sub  = sub_q + 2'd1;
            end else begin
              pos_d = '0;
              sub_d = '0;
              done  = 1'b1;
            end
          end
          SEG_START, SEG_ACK, SEG_NACK: begin
            if (cur_seg == SEG_ACK && sub_q == 2'd1 && item_i.sda_in) begin
              nack_d = 1'b1;
            end
            go_enter = 1'b1;
            if (sub_q < 2'd2) begin
              tgt_sub = sub_q + 2'd1;
            end else begin
              new_seg = 1'b1;
              tgt_pos = pos_q + PosW'(1);
            end
          end
          default: begin
            pos_d = '0;
            sub_d = '0;
          end
        endcase
      end else begin
        cnt_d = cnt_inc[TickCw-1:0];
      end
    end

    // segment entry: reset bit counter and load the byte to send
    tgt_seg = seg_at(rd_d, tgt_pos);
    if (new_seg) begin
      bit_d = '0;
      case (tgt_seg)
        SEG_SEND_DEV:  tx_d = dev_d;
        SEG_SEND_REG:  tx_d = reg_d;
        SEG_SEND_DAT:  tx_d = dat_d;
        SEG_SEND_DEVR: tx_d = dev_d + 8'd1;
        default:       tx_d = tx_d;
      endcase
    end

    // phase entry: set line levels
    if (go_enter) begin
      if (tgt_seg == SEG_END) begin
        pos_d = '0;
        sub_d = '0;
        done  = 1'b1;
      end else begin
        pos_d = tgt_pos;
        sub_d = tgt_sub;
        case (tgt_seg)
          SEG_START: begin
            if (tgt_sub == '0) begin
              sda_d = 1'b1;
              scl_d = 1'b1;
            end else if (tgt_sub == 2'd1) begin
              sda_d = 1'b0;
            end else begin
              scl_d = 1'b0;
            end
          end
          SEG_SEND_DEV, SEG_SEND_REG, SEG_SEND_DAT, SEG_SEND_DEVR: begin
            if (tgt_sub == '0) begin
              sda_d = tx_d[7];
            end else if (tgt_sub == 2'd1) begin
              scl_d = 1'b1;
            end else begin
              scl_d = 1'b0;
              if (bit_d == 3'd7) sda_d = 1'b1;
            end
          end
          SEG_ACK, SEG_NACK: begin
            if (tgt_sub == '0) begin
              sda_d = 1'b1;
            end else if (tgt_sub == 2'd1) begin
              scl_d = 1'b1;
            end else begin
              scl_d = 1'b0;
            end
          end
          SEG_RECV: begin
            scl_d = (tgt_sub == '0);
          end
          default: begin
            // stop
            if (tgt_sub == '0) begin
              sda_d = 1'b0;
            end else if (tgt_sub == 2'd1) begin
              scl_d = 1'b1;
            end else begin
              sda_d = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Result of this item
  always_comb begin
    res_o.scl_out   = scl_d;
    res_o.sda_out   = sda_d;
    res_o.busy_res  = (pos_d != '0);
    res_o.done_res  = done;
    res_o.read_data = rxres_d;
    res_o.nack_seen = nack_d;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= PhaseTicksRst;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_data_i;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sub_q   <= '0;
      cnt_q   <= '0;
      bit_q   <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      rxres_q <= '0;
      rd_q    <= 1'b0;
      dev_q   <= '0;
      reg_q   <= '0;
      dat_q   <= '0;
      nack_q  <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (step_i) begin
      pos_q   <= pos_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      rxres_q <= rxres_d;
      rd_q    <= rd_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      dat_q   <= dat_d;
      nack_q  <= nack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_register_access.sv =====
// Single-register I2C master, top level: input register, sequencer and
// result register. Depends on i2cm_pkg and i2cm_seq.
//
// Usage: every input transaction is either a tick (func = 0) that advances
// the bus timing by one tick, or a command (func = 1) that starts a register
// write or read when idle. Each input transaction yields exactly one result
// transaction carrying the SCL/SDA drive levels, busy, a done pulse, the last
// read byte and the sticky nack flag.
// Path: a result leaves through the input register, then the result
// register. Throughput: one transaction per cycle while out_ready_i is high;
// the sequencer works out its next state in combinational logic.
// phase_ticks is written through cfg_we_i/cfg_data_i (0 acts as 1) and sets
// how many ticks each bus phase is held.
// Reset: bus lines released, idle, nack flag and read byte cleared,
// phase_ticks = 30.
// Stall: while out_ready_i is low the result register holds, the input
// register fills, and in_ready_o drops once both are occupied.
`default_nettype none

module i2c_master_register_access import i2cm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TickCw-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o
);

  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;
  logic      advance;
  out_item_t res;

  // Stage handshake
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  i2cm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (in_q),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
